@@ rtl/core/kpl_pkg.sv @@
// ----------------------------------------------------------------------------
// kpl_pkg
// Shared types, key codes, status codes and character classing for the
// keypad password lock.
// ----------------------------------------------------------------------------
package kpl_pkg;

    // one character word on the keypad channel
    typedef logic [7:0] char_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_STORED       = 3'd0,
        ST_STRONG       = 3'd1,
        ST_WEAK         = 3'd2,
        ST_GRANTED      = 3'd3,
        ST_WRONG        = 3'd4,
        ST_LOCKED       = 3'd5,
        ST_IGNORED      = 3'd6,
        ST_NOT_ENROLLED = 3'd7
    } status_t;

    // item mode
    localparam logic MODE_ENROLL = 1'b0;
    localparam logic MODE_LOGIN  = 1'b1;

    // special keys
    localparam char_t KEY_ENTER = 8'd13;
    localparam char_t KEY_BACK  = 8'd8;

    // configuration register indexes
    localparam logic CFG_MIN_LENGTH   = 1'b0;
    localparam logic CFG_MAX_ATTEMPTS = 1'b1;

    // configuration reset values
    localparam logic [4:0] RST_MIN_LENGTH   = 5'd8;
    localparam logic [2:0] RST_MAX_ATTEMPTS = 3'd3;

    // attempt counter saturation
    localparam logic [2:0] WRONG_MAX = 3'd7;

    // class flag bits
    localparam logic [3:0] CLASS_UPPER   = 4'b0001;
    localparam logic [3:0] CLASS_LOWER   = 4'b0010;
    localparam logic [3:0] CLASS_DIGIT   = 4'b0100;
    localparam logic [3:0] CLASS_SPECIAL = 4'b1000;
    localparam logic [3:0] CLASS_ALL     = 4'b1111;

    // classify one ASCII code
    function automatic logic [3:0] char_class(input char_t c);
        logic [3:0] f;
        f = 4'b0000;
        if (c >= 8'd65 && c <= 8'd90) begin
            f = f | CLASS_UPPER;
        end
        if (c >= 8'd97 && c <= 8'd122) begin
            f = f | CLASS_LOWER;
        end
        if (c >= 8'd48 && c <= 8'd57) begin
            f = f | CLASS_DIGIT;
        end
        if ((c >= 8'd32 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
            (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126)) begin
            f = f | CLASS_SPECIAL;
        end
        return f;
    endfunction

endpackage

@@ rtl/core/keypad_password_lock.sv @@
// ----------------------------------------------------------------------------
// keypad_password_lock
// Password lock fed one ASCII word per cycle while m_ready allows: enroll words
// build the stored password, login words build a typed line checked against it on Enter.
// ----------------------------------------------------------------------------
// Pipeline: an accepted word waits in the input register, then moves into the
// result register, whose result word is driven on m_*.
// Throughput: one word per cycle; the input register and the result register
// both advance while the result side takes words.
// Reset (aresetn low, synchronous): no enrollment, no lockout, empty lines,
// min_length 8, max_attempts 3. The password stores are not cleared.
module keypad_password_lock #(
    parameter int MAX_LEN = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [4:0]        cfg_data,
    // character input
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_mode,
    input  kpl_pkg::char_t    s_char_code,
    // result output
    output logic              m_valid,
    input  logic              m_ready,
    output kpl_pkg::status_t  m_status,
    output logic [4:0]        m_line_length,
    output logic [3:0]        m_class_flags,
    output logic [2:0]        m_attempts_used,
    output logic              m_overflowed
);
    import kpl_pkg::*;

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CMP_W = (LEN_W > 5) ? LEN_W : 5;

    // configuration
    logic [4:0] min_length_reg;
    logic [2:0] max_attempts_reg;

    // input register
    logic       in_valid_reg;
    logic       in_mode_reg;
    char_t      in_char_reg;

    // result register
    logic       m_valid_reg;
    status_t    m_status_reg;
    logic [4:0] m_line_length_reg;
    logic [3:0] m_class_flags_reg;
    logic [2:0] m_attempts_used_reg;
    logic       m_overflowed_reg;

    // lock state
    char_t            stored_chars_reg [MAX_LEN];
    char_t            typed_chars_reg  [MAX_LEN];
    logic [LEN_W-1:0] stored_length_reg, stored_length_next;
    logic [LEN_W-1:0] typed_length_reg, typed_length_next;
    logic             enrolled_reg, enrolled_next;
    logic             enroll_active_reg, enroll_active_next;
    logic [3:0]       seen_classes_reg, seen_classes_next;
    logic             line_overflow_reg, line_overflow_next;
    logic [2:0]       wrong_count_reg, wrong_count_next;
    logic             locked_out_reg, locked_out_next;

    // per-word working signals
    logic             advance;
    logic             match;
    status_t          status_next;
    logic             stored_we;
    logic             typed_we;
    logic [IDX_W-1:0] stored_addr;
    logic [IDX_W-1:0] typed_addr;
    logic [LEN_W-1:0] base_length;
    logic [3:0]       base_classes;
    logic             base_overflow;
    logic             enroll_ok;
    logic [2:0]       wrong_bumped;
    logic [LEN_W-1:0] line_len_sel;

    // move a word from the input register into the result register
    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // compare typed line with stored password
    kpl_match #(
        .MAX_LEN (MAX_LEN)
    ) u_match (
        .stored_chars  (stored_chars_reg),
        .typed_chars   (typed_chars_reg),
        .stored_length (stored_length_reg),
        .typed_length  (typed_length_reg),
        .line_overflow (line_overflow_reg),
        .match         (match)
    );

    // next state and status for the word in the input register
    always_comb begin
        stored_length_next = stored_length_reg;
        typed_length_next  = typed_length_reg;
        enrolled_next      = enrolled_reg;
        enroll_active_next = enroll_active_reg;
        seen_classes_next  = seen_classes_reg;
        line_overflow_next = line_overflow_reg;
        wrong_count_next   = wrong_count_reg;
        locked_out_next    = locked_out_reg;
        status_next        = ST_STORED;
        stored_we          = 1'b0;
        typed_we           = 1'b0;
        stored_addr        = stored_length_reg[IDX_W-1:0];
        typed_addr         = typed_length_reg[IDX_W-1:0];
        base_length        = stored_length_reg;
        base_classes       = seen_classes_reg;
        base_overflow      = line_overflow_reg;
        enroll_ok          = 1'b0;
        wrong_bumped       = wrong_count_reg;

        if (in_mode_reg == MODE_ENROLL) begin
            // open a new enroll line
            if (!enroll_active_reg) begin
                base_length        = '0;
                base_classes       = 4'b0000;
                base_overflow      = 1'b0;
                typed_length_next  = '0;
                enrolled_next      = 1'b0;
                enroll_active_next = 1'b1;
            end
            stored_length_next = base_length;
            seen_classes_next  = base_classes;
            line_overflow_next = base_overflow;
            stored_addr        = base_length[IDX_W-1:0];

            if (in_char_reg == KEY_ENTER) begin
                enroll_ok = !base_overflow && (base_classes == CLASS_ALL) &&
                            (CMP_W'(base_length) >= CMP_W'(min_length_reg));
                enroll_active_next = 1'b0;
                line_overflow_next = 1'b0;
                if (enroll_ok) begin
                    enrolled_next    = 1'b1;
                    wrong_count_next = '0;
                    locked_out_next  = 1'b0;
                    status_next      = ST_STRONG;
                end else begin
                    enrolled_next = 1'b0;
                    status_next   = ST_WEAK;
                end
            end else if (base_length >= LEN_W'(MAX_LEN)) begin
                line_overflow_next = 1'b1;
                status_next        = ST_IGNORED;
            end else begin
                stored_we          = 1'b1;
                stored_length_next = base_length + 1'b1;
                seen_classes_next  = base_classes | char_class(in_char_reg);
            end
        end else begin
            if (enroll_active_reg) begin
                status_next = ST_IGNORED;
            end else if (!enrolled_reg) begin
                status_next = ST_NOT_ENROLLED;
            end else if (locked_out_reg) begin
                status_next = ST_LOCKED;
            end else if (in_char_reg == KEY_ENTER) begin
                typed_length_next  = '0;
                line_overflow_next = 1'b0;
                if (match) begin
                    status_next = ST_GRANTED;
                end else begin
                    // count a wrong line, saturating
                    if (wrong_count_reg < WRONG_MAX) begin
                        wrong_bumped = wrong_count_reg + 1'b1;
                    end
                    wrong_count_next = wrong_bumped;
                    if (wrong_bumped >= max_attempts_reg) begin
                        locked_out_next = 1'b1;
                        status_next     = ST_LOCKED;
                    end else begin
                        status_next = ST_WRONG;
                    end
                end
            end else if (in_char_reg == KEY_BACK) begin
                if (typed_length_reg != '0) begin
                    typed_length_next = typed_length_reg - 1'b1;
                end
            end else if (typed_length_reg >= LEN_W'(MAX_LEN)) begin
                line_overflow_next = 1'b1;
                status_next        = ST_IGNORED;
            end else begin
                typed_we          = 1'b1;
                typed_length_next = typed_length_reg + 1'b1;
            end
        end

        line_len_sel = enroll_active_next ? stored_length_next : typed_length_next;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_length_reg   <= RST_MIN_LENGTH;
            max_attempts_reg <= RST_MAX_ATTEMPTS;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_MIN_LENGTH) begin
                min_length_reg <= cfg_data;
            end else begin
                max_attempts_reg <= cfg_data[2:0];
            end
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg <= s_mode;
            in_char_reg <= s_char_code;
        end
    end

    // lock state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_length_reg <= '0;
            typed_length_reg  <= '0;
            enrolled_reg      <= 1'b0;
            enroll_active_reg <= 1'b0;
            seen_classes_reg  <= 4'b0000;
            line_overflow_reg <= 1'b0;
            wrong_count_reg   <= '0;
            locked_out_reg    <= 1'b0;
        end else if (advance) begin
            stored_length_reg <= stored_length_next;
            typed_length_reg  <= typed_length_next;
            enrolled_reg      <= enrolled_next;
            enroll_active_reg <= enroll_active_next;
            seen_classes_reg  <= seen_classes_next;
            line_overflow_reg <= line_overflow_next;
            wrong_count_reg   <= wrong_count_next;
            locked_out_reg    <= locked_out_next;
        end
    end

    // character stores
    always_ff @(posedge aclk) begin
        if (advance && stored_we) begin
            stored_chars_reg[stored_addr] <= in_char_reg;
        end
        if (advance && typed_we) begin
            typed_chars_reg[typed_addr] <= in_char_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_status_reg        <= status_next;
            m_line_length_reg   <= 5'(line_len_sel);
            m_class_flags_reg   <= seen_classes_next;
            m_attempts_used_reg <= wrong_count_next;
            m_overflowed_reg    <= line_overflow_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_line_length   = m_line_length_reg;
    assign m_class_flags   = m_class_flags_reg;
    assign m_attempts_used = m_attempts_used_reg;
    assign m_overflowed    = m_overflowed_reg;

    // line lengths stay within the stores
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (stored_length_reg <= LEN_W'(MAX_LEN)) && (typed_length_reg <= LEN_W'(MAX_LEN)))
        else $error("line length beyond store depth");

    // an open enroll line means no valid password
    a_enroll_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        enroll_active_reg |-> !enrolled_reg)
        else $error("enrolled while enroll line open");

    // access granted only when enrolled and not locked
    a_grant_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && status_next == ST_GRANTED) |-> (enrolled_reg && !locked_out_reg))
        else $error("grant without valid enrollment");

    // lockout only follows a counted wrong line
    a_lock_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(locked_out_reg) |-> (wrong_count_reg != '0))
        else $error("lockout with zero wrong lines");

endmodule

@@ rtl/core/kpl_match.sv @@
// ----------------------------------------------------------------------------
// kpl_match
// Whole-line compare of the typed line against the stored password.
// ----------------------------------------------------------------------------
module kpl_match #(
    parameter int MAX_LEN = 16,
    localparam int LEN_W = $clog2(MAX_LEN + 1)
) (
    input  kpl_pkg::char_t   stored_chars [MAX_LEN],
    input  kpl_pkg::char_t   typed_chars  [MAX_LEN],
    input  logic [LEN_W-1:0] stored_length,
    input  logic [LEN_W-1:0] typed_length,
    input  logic             line_overflow,
    output logic             match
);
    import kpl_pkg::*;

    logic [MAX_LEN-1:0] differ;

    // flag each differing position inside the typed line
    always_comb begin
        differ = '0;
        for (int i = 0; i < MAX_LEN; i++) begin
            if ((LEN_W'(i) < typed_length) && (typed_chars[i] != stored_chars[i])) begin
                differ[i] = 1'b1;
            end
        end
    end

    // an overflowed line never matches
    assign match = !line_overflow && (typed_length == stored_length) && (differ == '0);

endmodule
